// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/kltd_pkg.sv =====
// ----------------------------------------------------------------------------
// kltd_pkg
// shared types and codes of the keyed table with lazy deletion
// ----------------------------------------------------------------------------
package kltd_pkg;

   localparam int FUNC_W  = 2;
   localparam int KEY_W   = 31;
   localparam int PAY_W   = 64;
   localparam int MARK_W  = 2;
   localparam int STAT_W  = 2;
   localparam int INDEX_W = 4;
   localparam int USED_W  = 5;

   localparam logic [FUNC_W-1:0] FUNC_INSERT  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOOKUP  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_DELETE  = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_COMPACT = 2'd3;

   localparam logic [MARK_W-1:0] MARK_EMPTY   = 2'd0;
   localparam logic [MARK_W-1:0] MARK_LIVE    = 2'd1;
   localparam logic [MARK_W-1:0] MARK_DELETED = 2'd2;

   localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
   localparam logic [STAT_W-1:0] STAT_DUP  = 2'd2;
   localparam logic [STAT_W-1:0] STAT_MISS = 2'd3;

   typedef struct packed {
      logic [MARK_W-1:0] mark;
      logic [KEY_W-1:0]  key;
      logic [PAY_W-1:0]  payload;
   } kltd_entry_type;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [INDEX_W-1:0] hit_index;
      logic [PAY_W-1:0]   hit_payload;
      logic [USED_W-1:0]  used_count;
   } kltd_rsp_type;

endpackage

// ===== hw/rtl/keyed_table_lazy_delete_core.sv =====
// ----------------------------------------------------------------------------
// keyed_table_lazy_delete_core
// keyed slot table with insert, lookup, lazy delete and compact
// ----------------------------------------------------------------------------
// Used slots always sit packed at slots 0 to used_count-1 of a single slot
// memory (mark, key and payload per word, one read and one write per cycle).
// Every operation but an insert into a full table walks those used slots,
// one memory read per cycle; after the reads come the read latency, the
// close of the scan and the load of the output register, then the result
// beat. An insert stops early on a duplicate key, lookup and delete stop
// on the first live match, an insert into a full table goes straight to the
// result without a scan, and compact always walks all used slots, rewriting
// the surviving ones in place behind the read pointer.
// One operation is in flight at a time; the output register lets the next
// request in while a result beat still waits on rsp_ready.
// ----------------------------------------------------------------------------
module keyed_table_lazy_delete_core #(
   parameter int TABLE_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [30:0] req_key,
   input  logic [63:0] req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_hit_index,
   output logic [63:0] rsp_hit_payload,
   output logic [4:0]  rsp_used_count
);
   import kltd_pkg::*;

   localparam int IW = $clog2(TABLE_SLOTS);

   logic           mem_wr_en;
   logic [IW-1:0]  mem_wr_addr;
   kltd_entry_type mem_wr_data;
   logic           mem_rd_en;
   logic [IW-1:0]  mem_rd_addr;
   kltd_entry_type mem_rd_data;
   logic           out_free;
   logic           out_load;
   kltd_rsp_type   out_data;

   kltd_ctrl #(
      .TABLE_SLOTS(TABLE_SLOTS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_func    (req_func),
      .req_key     (req_key),
      .req_payload (req_payload),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .out_free    (out_free),
      .out_load    (out_load),
      .out_data    (out_data)
   );

   kltd_mem #(
      .DEPTH(TABLE_SLOTS),
      .WIDTH($bits(kltd_entry_type))
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   kltd_out u_out (
      .clock           (clock),
      .reset           (reset),
      .load            (out_load),
      .load_data       (out_data),
      .free            (out_free),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_hit_index   (rsp_hit_index),
      .rsp_hit_payload (rsp_hit_payload),
      .rsp_used_count  (rsp_used_count)
   );

endmodule

// ===== hw/rtl/kltd_mem.sv =====
// ----------------------------------------------------------------------------
// kltd_mem
// slot memory, one write port and one read port with registered read data
// ----------------------------------------------------------------------------
module kltd_mem #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 97
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] slot_mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= slot_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/kltd_out.sv =====
// ----------------------------------------------------------------------------
// kltd_out
// result output register, frees the sequencer while a beat waits
// ----------------------------------------------------------------------------
module kltd_out (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  kltd_pkg::kltd_rsp_type  load_data,
   output logic                    free,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [1:0]              rsp_status,
   output logic [3:0]              rsp_hit_index,
   output logic [63:0]             rsp_hit_payload,
   output logic [4:0]              rsp_used_count
);
   import kltd_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   kltd_rsp_type data_ff;

   assign free     = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_status      = data_ff.status;
   assign rsp_hit_index   = data_ff.hit_index;
   assign rsp_hit_payload = data_ff.hit_payload;
   assign rsp_used_count  = data_ff.used_count;

endmodule

// ===== hw/rtl/kltd_ctrl.sv =====
// ----------------------------------------------------------------------------
// kltd_ctrl
// operation sequencer, scans the used slots one read per cycle
// ----------------------------------------------------------------------------
module kltd_ctrl #(
   parameter int TABLE_SLOTS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_func,
   input  logic [30:0]                          req_key,
   input  logic [63:0]                          req_payload,
   output logic                                 mem_wr_en,
   output logic [$clog2(TABLE_SLOTS)-1:0]       mem_wr_addr,
   output kltd_pkg::kltd_entry_type             mem_wr_data,
   output logic                                 mem_rd_en,
   output logic [$clog2(TABLE_SLOTS)-1:0]       mem_rd_addr,
   input  kltd_pkg::kltd_entry_type             mem_rd_data,
   input  logic                                 out_free,
   output logic                                 out_load,
   output kltd_pkg::kltd_rsp_type               out_data
);
   import kltd_pkg::*;

   localparam int IW = $clog2(TABLE_SLOTS);
   localparam int CW = $clog2(TABLE_SLOTS + 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_SLOTS);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [FUNC_W-1:0] op_ff, op_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [PAY_W-1:0]  pay_ff, pay_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [CW-1:0]     ptr_ff, ptr_in;
   logic [CW-1:0]     wr_ff, wr_in;
   logic              pend_ff, pend_in;
   logic [IW-1:0]     pidx_ff, pidx_in;
   kltd_rsp_type      res_ff, res_in;

   logic              issue;
   logic              key_eq;
   logic              live_hit;
   logic              accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign issue     = (state_ff == S_SCAN) && (ptr_ff < cnt_ff);
   assign key_eq    = (mem_rd_data.key == key_ff);
   assign live_hit  = pend_ff && key_eq && (mem_rd_data.mark == MARK_LIVE);

   assign mem_rd_en   = issue;
   assign mem_rd_addr = ptr_ff[IW-1:0];
   assign out_load    = (state_ff == S_DONE) && out_free;
   assign out_data    = res_ff;

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      key_in      = key_ff;
      pay_in      = pay_ff;
      cnt_in      = cnt_ff;
      ptr_in      = ptr_ff;
      wr_in       = wr_ff;
      pend_in     = 1'b0;
      pidx_in     = ptr_ff[IW-1:0];
      res_in      = res_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = pidx_ff;
      mem_wr_data = mem_rd_data;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in  = req_func;
               key_in = req_key;
               pay_in = req_payload;
               ptr_in = '0;
               wr_in  = '0;
               if (req_func == FUNC_INSERT && cnt_ff == FULL_CNT) begin
                  res_in   = '{STAT_FULL, '0, '0, USED_W'(cnt_ff)};
                  state_in = S_DONE;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            pend_in = issue;
            if (issue) begin
               ptr_in = ptr_ff + CW'(1);
            end
            if (op_ff == FUNC_INSERT && pend_ff && key_eq) begin
               res_in   = '{STAT_DUP, INDEX_W'(pidx_ff), '0, USED_W'(cnt_ff)};
               state_in = S_DONE;
            end else if (op_ff == FUNC_LOOKUP && live_hit) begin
               res_in   = '{STAT_OK, INDEX_W'(pidx_ff), mem_rd_data.payload,
                            USED_W'(cnt_ff)};
               state_in = S_DONE;
            end else if (op_ff == FUNC_DELETE && live_hit) begin
               mem_wr_en        = 1'b1;
               mem_wr_data.mark = MARK_DELETED;
               res_in   = '{STAT_OK, INDEX_W'(pidx_ff), '0, USED_W'(cnt_ff)};
               state_in = S_DONE;
            end else if (op_ff == FUNC_COMPACT && pend_ff
                         && mem_rd_data.mark != MARK_DELETED) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = wr_ff[IW-1:0];
               wr_in       = wr_ff + CW'(1);
            end else if (!issue && !pend_ff) begin
               state_in = S_DONE;
               case (op_ff)
                  FUNC_INSERT: begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = cnt_ff[IW-1:0];
                     mem_wr_data = '{MARK_LIVE, key_ff, pay_ff};
                     cnt_in      = cnt_ff + CW'(1);
                     res_in      = '{STAT_OK, INDEX_W'(cnt_ff[IW-1:0]), '0,
                                     USED_W'(cnt_ff + CW'(1))};
                  end
                  FUNC_COMPACT: begin
                     cnt_in = wr_ff;
                     res_in = '{STAT_OK, '0, '0, USED_W'(wr_ff)};
                  end
                  default: begin
                     res_in = '{STAT_MISS, '0, '0, USED_W'(cnt_ff)};
                  end
               endcase
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      key_ff  <= key_in;
      pay_ff  <= pay_in;
      ptr_ff  <= ptr_in;
      wr_ff   <= wr_in;
      pidx_ff <= pidx_in;
      res_ff  <= res_in;
   end

endmodule

// ===== hw/rtl/kltd_checker.sv =====
// ----------------------------------------------------------------------------
// kltd_checker
// port-level assertions for keyed_table_lazy_delete_core
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kltd_checker #(
   parameter int TABLE_SLOTS = 16
) (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [3:0]  rsp_hit_index,
   input logic [63:0] rsp_hit_payload,
   input logic [4:0]  rsp_used_count
);
   import kltd_pkg::*;

   // a held result beat keeps its contents
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_hit_index) && $stable(rsp_hit_payload) && $stable(rsp_used_count))

   // one operation at a time
   `ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready)

   // a full table reports no slot and no payload
   `ASSERT_SAME(a_full_clean, clock, reset, rsp_valid && rsp_status == STAT_FULL, rsp_hit_index == 4'd0 && rsp_hit_payload == 64'd0)

   // a nonzero payload only comes with a successful lookup
   `ASSERT_SAME(a_payload_ok, clock, reset, rsp_valid && rsp_hit_payload != 64'd0, rsp_status == STAT_OK)

   // the used count never exceeds the table
   `ASSERT_SAME(a_count_range, clock, reset, rsp_valid, int'(rsp_used_count) <= TABLE_SLOTS)

endmodule

bind keyed_table_lazy_delete_core kltd_checker #(
   .TABLE_SLOTS(TABLE_SLOTS)
) u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_status      (rsp_status),
   .rsp_hit_index   (rsp_hit_index),
   .rsp_hit_payload (rsp_hit_payload),
   .rsp_used_count  (rsp_used_count)
);
